// ===== hdl/noc_route_compute_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the route computation block.
// Each macro expands to one labeled concurrent assertion clocked on the
// rising edge and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef NOC_ROUTE_COMPUTE_TOP_MACROS_SVH
`define NOC_ROUTE_COMPUTE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NRC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrc_pkg
// Shared widths, codes and beat types of the route computation block.
// ----------------------------------------------------------------------------
`default_nettype none

package nrc_pkg;

  // Field widths.
  localparam int COORD_BITS     = 4;
  localparam int ALG_BITS       = 3;
  localparam int RING_BITS      = 5;
  localparam int PORT_BITS      = 3;
  localparam int VC_BITS        = 2;
  localparam int LEVEL_BITS     = 8;
  localparam int NUM_VCS        = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 5;
  localparam int OFF_BITS       = COORD_BITS + 1;
  localparam int CNT_BITS       = $clog2(NUM_VCS);

  // Output port codes.
  localparam logic [PORT_BITS-1:0] PORT_EJECT = 3'd0;
  localparam logic [PORT_BITS-1:0] PORT_MX    = 3'd1;
  localparam logic [PORT_BITS-1:0] PORT_PX    = 3'd2;
  localparam logic [PORT_BITS-1:0] PORT_MY    = 3'd3;
  localparam logic [PORT_BITS-1:0] PORT_PY    = 3'd4;
  localparam logic [PORT_BITS-1:0] PORT_MZ    = 3'd5;
  localparam logic [PORT_BITS-1:0] PORT_PZ    = 3'd6;

  // Virtual channel codes.
  localparam logic [VC_BITS-1:0] VC0 = 2'd0;
  localparam logic [VC_BITS-1:0] VC1 = 2'd1;
  localparam logic [VC_BITS-1:0] VC2 = 2'd2;
  localparam logic [VC_BITS-1:0] VC3 = 2'd3;

  // Routing algorithm codes.
  localparam logic [ALG_BITS-1:0] ALG_XY       = 3'd0;
  localparam logic [ALG_BITS-1:0] ALG_TORUS_XY = 3'd1;
  localparam logic [ALG_BITS-1:0] ALG_ADAPT_VN = 3'd2;
  localparam logic [ALG_BITS-1:0] ALG_TURN     = 3'd3;
  localparam logic [ALG_BITS-1:0] ALG_XYZ      = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_NODE_X    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NODE_Y    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NODE_Z    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALGORITHM = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RING_SIZE = 3'd4;

  localparam logic [RING_BITS-1:0] RING_SIZE_RESET = 5'd16;

  // Request beat.
  typedef struct packed {
    logic [COORD_BITS-1:0] dest_x;
    logic [COORD_BITS-1:0] dest_y;
    logic [COORD_BITS-1:0] dest_z;
    logic [PORT_BITS-1:0]  req_port_in;
    logic [VC_BITS-1:0]    req_vc_in;
    logic [LEVEL_BITS-1:0] level_mx_vc0;
    logic [LEVEL_BITS-1:0] level_px_vc0;
    logic [LEVEL_BITS-1:0] level_px_vc1;
    logic [LEVEL_BITS-1:0] level_my_vc0;
    logic [LEVEL_BITS-1:0] level_my_vc2;
    logic [LEVEL_BITS-1:0] level_py_vc0;
    logic [LEVEL_BITS-1:0] level_py_vc3;
  } in_beat_t;

  // Candidate beat.
  typedef struct packed {
    logic [PORT_BITS-1:0] out_port;
    logic [VC_BITS-1:0]   out_vc;
    logic [PORT_BITS-1:0] req_port;
    logic [VC_BITS-1:0]   req_vc;
    logic                 last;
  } out_beat_t;

  // Configuration register set.
  typedef struct packed {
    logic [COORD_BITS-1:0] node_x;
    logic [COORD_BITS-1:0] node_y;
    logic [COORD_BITS-1:0] node_z;
    logic [ALG_BITS-1:0]   algorithm;
    logic [RING_BITS-1:0]  ring_size;
  } cfg_t;

  // Occupancy comparisons used by the adaptive modes.
  typedef struct packed {
    logic my2_gt_mx0;
    logic my2_gt_px1;
    logic py3_gt_mx0;
    logic py3_gt_px1;
    logic my0_gt_mx0;
    logic py0_gt_mx0;
    logic py0_gt_px0;
  } cmp_t;

  // First stage result: signed offsets and comparisons.
  typedef struct packed {
    logic signed [OFF_BITS-1:0] xo;
    logic signed [OFF_BITS-1:0] yo;
    logic signed [OFF_BITS-1:0] zo;
    cmp_t                       cmp;
    logic [PORT_BITS-1:0]       req_port;
    logic [VC_BITS-1:0]         req_vc;
  } off_t;

  // Second stage result: chosen port, first VC and whether all VCs follow.
  typedef struct packed {
    logic [PORT_BITS-1:0] port;
    logic [VC_BITS-1:0]   vc;
    logic                 all_vcs;
    logic [PORT_BITS-1:0] req_port;
    logic [VC_BITS-1:0]   req_vc;
  } route_t;

endpackage

`default_nettype wire

// ===== hdl/nrc_offset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrc_offset
// First pipeline stage: coordinate offsets and occupancy comparisons.
// ----------------------------------------------------------------------------
`default_nettype none

module nrc_offset (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nrc_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nrc_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output nrc_pkg::off_t          out_data
);

  logic          ready;
  nrc_pkg::off_t stage_next;

  assign ready    = !out_valid || !out_stall;
  assign in_stall = !ready;

  // Offsets are one bit wider than the coordinates so the sign survives.
  always_comb begin
    stage_next.xo = $signed({1'b0, in_data.dest_x}) - $signed({1'b0, cfg.node_x});
    stage_next.yo = $signed({1'b0, in_data.dest_y}) - $signed({1'b0, cfg.node_y});
    stage_next.zo = $signed({1'b0, in_data.dest_z}) - $signed({1'b0, cfg.node_z});
    stage_next.cmp.my2_gt_mx0 = in_data.level_my_vc2 > in_data.level_mx_vc0;
    stage_next.cmp.my2_gt_px1 = in_data.level_my_vc2 > in_data.level_px_vc1;
    stage_next.cmp.py3_gt_mx0 = in_data.level_py_vc3 > in_data.level_mx_vc0;
    stage_next.cmp.py3_gt_px1 = in_data.level_py_vc3 > in_data.level_px_vc1;
    stage_next.cmp.my0_gt_mx0 = in_data.level_my_vc0 > in_data.level_mx_vc0;
    stage_next.cmp.py0_gt_mx0 = in_data.level_py_vc0 > in_data.level_mx_vc0;
    stage_next.cmp.py0_gt_px0 = in_data.level_py_vc0 > in_data.level_px_vc0;
    stage_next.req_port = in_data.req_port_in;
    stage_next.req_vc   = in_data.req_vc_in;
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nrc_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrc_decide
// Second pipeline stage: picks the output port and VC for each algorithm.
// ----------------------------------------------------------------------------
`default_nettype none

module nrc_decide (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nrc_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nrc_pkg::off_t     in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output nrc_pkg::route_t        out_data
);

  logic                            ready;
  nrc_pkg::route_t                 route_next;
  logic                            is3d;
  logic                            x_neg, y_neg, z_neg;
  logic                            x_zero, y_zero, z_zero;
  logic [nrc_pkg::COORD_BITS-1:0]  x_abs, y_abs;
  logic                            x_near, y_near;

  assign ready    = !out_valid || !out_stall;
  assign in_stall = !ready;

  // Sign, zero and half-ring tests on the offsets.
  always_comb begin
    is3d   = cfg.algorithm == nrc_pkg::ALG_XYZ;
    x_neg  = in_data.xo[nrc_pkg::OFF_BITS-1];
    y_neg  = in_data.yo[nrc_pkg::OFF_BITS-1];
    z_neg  = in_data.zo[nrc_pkg::OFF_BITS-1];
    x_zero = in_data.xo == '0;
    y_zero = in_data.yo == '0;
    z_zero = in_data.zo == '0;
    x_abs  = x_neg ? nrc_pkg::COORD_BITS'(-in_data.xo) : nrc_pkg::COORD_BITS'(in_data.xo);
    y_abs  = y_neg ? nrc_pkg::COORD_BITS'(-in_data.yo) : nrc_pkg::COORD_BITS'(in_data.yo);
    // The magnitude fits in the coordinate width, so doubling it fits in five bits.
    x_near = {x_abs, 1'b0} <= cfg.ring_size;
    y_near = {y_abs, 1'b0} <= cfg.ring_size;
  end

  // Route selection.
  always_comb begin
    route_next.port     = nrc_pkg::PORT_EJECT;
    route_next.vc       = nrc_pkg::VC0;
    route_next.all_vcs  = 1'b0;
    route_next.req_port = in_data.req_port;
    route_next.req_vc   = in_data.req_vc;
    if (x_zero && y_zero && (!is3d || z_zero)) begin
      route_next.port = nrc_pkg::PORT_EJECT;
    end else begin
      unique case (cfg.algorithm)
        nrc_pkg::ALG_TORUS_XY: begin
          // Short way round the ring, with the dateline VC by direction.
          if (x_neg) begin
            route_next.port = x_near ? nrc_pkg::PORT_MX : nrc_pkg::PORT_PX;
            route_next.vc   = nrc_pkg::VC0;
          end else if (!x_zero) begin
            route_next.port = x_near ? nrc_pkg::PORT_PX : nrc_pkg::PORT_MX;
            route_next.vc   = nrc_pkg::VC1;
          end else if (y_neg) begin
            route_next.port = y_near ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PY;
            route_next.vc   = nrc_pkg::VC0;
          end else begin
            route_next.port = y_near ? nrc_pkg::PORT_PY : nrc_pkg::PORT_MY;
            route_next.vc   = nrc_pkg::VC1;
          end
        end
        nrc_pkg::ALG_ADAPT_VN: begin
          // Each direction owns one VC; a tie picks the x port.
          if (x_zero) begin
            route_next.port = y_neg ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PY;
            route_next.vc   = y_neg ? nrc_pkg::VC2 : nrc_pkg::VC3;
          end else if (y_zero) begin
            route_next.port = x_neg ? nrc_pkg::PORT_MX : nrc_pkg::PORT_PX;
            route_next.vc   = x_neg ? nrc_pkg::VC0 : nrc_pkg::VC1;
          end else if (y_neg && x_neg) begin
            route_next.port = in_data.cmp.my2_gt_mx0 ? nrc_pkg::PORT_MY : nrc_pkg::PORT_MX;
            route_next.vc   = in_data.cmp.my2_gt_mx0 ? nrc_pkg::VC2 : nrc_pkg::VC0;
          end else if (y_neg) begin
            route_next.port = in_data.cmp.my2_gt_px1 ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PX;
            route_next.vc   = in_data.cmp.my2_gt_px1 ? nrc_pkg::VC2 : nrc_pkg::VC1;
          end else if (x_neg) begin
            route_next.port = in_data.cmp.py3_gt_mx0 ? nrc_pkg::PORT_PY : nrc_pkg::PORT_MX;
            route_next.vc   = in_data.cmp.py3_gt_mx0 ? nrc_pkg::VC3 : nrc_pkg::VC0;
          end else begin
            route_next.port = in_data.cmp.py3_gt_px1 ? nrc_pkg::PORT_PY : nrc_pkg::PORT_PX;
            route_next.vc   = in_data.cmp.py3_gt_px1 ? nrc_pkg::VC3 : nrc_pkg::VC1;
          end
        end
        nrc_pkg::ALG_TURN: begin
          // Turn model on VC 0; the +x, -y quadrant always goes +x.
          route_next.vc = nrc_pkg::VC0;
          if (x_zero) begin
            route_next.port = y_neg ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PY;
          end else if (y_zero) begin
            route_next.port = x_neg ? nrc_pkg::PORT_MX : nrc_pkg::PORT_PX;
          end else if (y_neg && x_neg) begin
            route_next.port = in_data.cmp.my0_gt_mx0 ? nrc_pkg::PORT_MY : nrc_pkg::PORT_MX;
          end else if (y_neg) begin
            route_next.port = nrc_pkg::PORT_PX;
          end else if (x_neg) begin
            route_next.port = in_data.cmp.py0_gt_mx0 ? nrc_pkg::PORT_PY : nrc_pkg::PORT_MX;
          end else begin
            route_next.port = in_data.cmp.py0_gt_px0 ? nrc_pkg::PORT_PY : nrc_pkg::PORT_PX;
          end
        end
        default: begin
          // Dimension order (z, then y, then x) offering every VC of the port.
          route_next.all_vcs = 1'b1;
          if (is3d && !z_zero) begin
            route_next.port = z_neg ? nrc_pkg::PORT_MZ : nrc_pkg::PORT_PZ;
          end else if (!y_zero) begin
            route_next.port = y_neg ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PY;
          end else begin
            route_next.port = x_neg ? nrc_pkg::PORT_MX : nrc_pkg::PORT_PX;
          end
        end
      endcase
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_data <= route_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nrc_expand.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrc_expand
// Output stage: turns one route into one or several candidate beats.
// ----------------------------------------------------------------------------
`default_nettype none

module nrc_expand (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nrc_pkg::route_t   in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output nrc_pkg::out_beat_t     out_data
);

  logic [nrc_pkg::PORT_BITS-1:0] port;
  logic [nrc_pkg::VC_BITS-1:0]   vc;
  logic [nrc_pkg::CNT_BITS-1:0]  remain;
  logic [nrc_pkg::PORT_BITS-1:0] req_port;
  logic [nrc_pkg::VC_BITS-1:0]   req_vc;
  logic                          take;
  logic                          is_last;
  logic                          ready;

  assign is_last  = remain == '0;
  assign take     = out_valid && !out_stall;
  assign ready    = !out_valid || (take && is_last);
  assign in_stall = !ready;

  assign out_data.out_port = port;
  assign out_data.out_vc   = vc;
  assign out_data.req_port = req_port;
  assign out_data.req_vc   = req_vc;
  assign out_data.last     = is_last;

  // Valid bit and beat counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remain    <= '0;
    end else if (ready) begin
      out_valid <= in_valid;
      remain    <= in_data.all_vcs ? nrc_pkg::CNT_BITS'(nrc_pkg::NUM_VCS - 1) : '0;
    end else if (take) begin
      remain <= remain - 1'b1;
    end
  end

  // Candidate payload; the VC steps up once per beat taken.
  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      port     <= in_data.port;
      vc       <= in_data.vc;
      req_port <= in_data.req_port;
      req_vc   <= in_data.req_vc;
    end else if (take && !is_last) begin
      vc <= vc + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/noc_route_compute_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noc_route_compute_top
// Route computation for a mesh or torus router: one header request in, one
// to four candidate (output port, VC) beats out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        input      in_valid / in_stall    nrc_pkg::in_beat_t
//  out       output     out_valid / out_stall  nrc_pkg::out_beat_t
//  cfg       input      cfg_wr_en              cfg_index, cfg_wdata
//
//  A request passes the offset, decide and expand registers to its first beat.
//  Non-eject XY, XYZ and unused-code requests give four beats, others one;
//  the output register sends one beat per cycle while out_stall is low.
//  A new request is accepted every cycle while the last stage keeps up.
//  Reset clears the stage valid bits and loads the register reset values.
//  A stall on the output backs up stage by stage; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "noc_route_compute_top_macros.svh"

module noc_route_compute_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [nrc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [nrc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire nrc_pkg::in_beat_t                     in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output nrc_pkg::out_beat_t                         out_data
);

  nrc_pkg::cfg_t   cfg;
  logic            off_valid;
  logic            off_stall;
  nrc_pkg::off_t   off_data;
  logic            route_valid;
  logic            route_stall;
  nrc_pkg::route_t route_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_x    <= '0;
      cfg.node_y    <= '0;
      cfg.node_z    <= '0;
      cfg.algorithm <= nrc_pkg::ALG_XY;
      cfg.ring_size <= nrc_pkg::RING_SIZE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        nrc_pkg::REG_NODE_X:    cfg.node_x    <= cfg_wdata[nrc_pkg::COORD_BITS-1:0];
        nrc_pkg::REG_NODE_Y:    cfg.node_y    <= cfg_wdata[nrc_pkg::COORD_BITS-1:0];
        nrc_pkg::REG_NODE_Z:    cfg.node_z    <= cfg_wdata[nrc_pkg::COORD_BITS-1:0];
        nrc_pkg::REG_ALGORITHM: cfg.algorithm <= cfg_wdata[nrc_pkg::ALG_BITS-1:0];
        nrc_pkg::REG_RING_SIZE: cfg.ring_size <= cfg_wdata[nrc_pkg::RING_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage 1: offsets and occupancy comparisons.
  nrc_offset u_offset (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (off_valid),
    .out_stall (off_stall),
    .out_data  (off_data)
  );

  // Stage 2: route decision.
  nrc_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (off_valid),
    .in_stall  (off_stall),
    .in_data   (off_data),
    .out_valid (route_valid),
    .out_stall (route_stall),
    .out_data  (route_data)
  );

  // Stage 3: candidate beats.
  nrc_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (route_valid),
    .in_stall  (route_stall),
    .in_data   (route_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A taken beat that is not the last is followed by another beat.
  `NRC_ASSERT_NEXT(a_more_beats, clk, rst, out_valid && !out_stall && !out_data.last, out_valid, "candidate list ended without a last beat")

  // Later beats of a request stay on the port and step the VC by one.
  `NRC_ASSERT_NEXT(a_vc_step, clk, rst, out_valid && !out_stall && !out_data.last, (out_data.out_port == $past(out_data.out_port)) && (out_data.out_vc == nrc_pkg::VC_BITS'($past(out_data.out_vc) + 1'b1)), "multi-beat request changed port or skipped a VC")

  // Local eject is always a single beat on VC 0.
  `NRC_ASSERT_SAME(a_eject_single, clk, rst, out_valid && (out_data.out_port == nrc_pkg::PORT_EJECT), out_data.last && (out_data.out_vc == nrc_pkg::VC0), "eject candidate is not a single VC 0 beat")

endmodule

`default_nettype wire

// ===== bench/noc_route_compute_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noc_route_compute_top_tb
// Self-checking bench for the route computation block. It starts with a
// table of directed header requests, then runs randomized requests under
// changing router settings. Every candidate beat is checked field by field
// against typed-in or predicted candidates; both channels may be throttled.
// ----------------------------------------------------------------------------

module noc_route_compute_top_tb;

  localparam int NUM_DIR      = 25;
  localparam int DRAIN_CYCLES = 8;
  localparam int WAIT_LIMIT   = 20000;
  localparam int SEG_ITEMS    = 6;
  localparam int HOLD_ITEMS   = 20;
  localparam int HOLD_CYCLES  = 80;

  // Algorithm codes that the block treats as XY.
  localparam logic [nrc_pkg::ALG_BITS-1:0] ALG_UNUSED_LO = 3'd5;
  localparam logic [nrc_pkg::ALG_BITS-1:0] ALG_UNUSED_HI = 3'd7;

  // One directed request, with its candidates typed in where they are obvious.
  typedef struct packed {
    nrc_pkg::cfg_t                 cfg;
    nrc_pkg::in_beat_t             req;
    logic                          fixed;
    logic [nrc_pkg::PORT_BITS-1:0] port;
    logic [nrc_pkg::VC_BITS-1:0]   vc;
    logic [2:0]                    count;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [nrc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [nrc_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  nrc_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nrc_pkg::out_beat_t out_data;

  // Router settings as the block should currently hold them.
  nrc_pkg::cfg_t router_cfg;
  nrc_pkg::out_beat_t cand_q[$];
  dir_row_t dir_rows[NUM_DIR];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int errors = 0;
  int n_requests = 0;
  int n_beats = 0;
  int n_settings = 0;

  noc_route_compute_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Queue the candidates of one request: count consecutive VCs on one port.
  function automatic void push_cands(logic [nrc_pkg::PORT_BITS-1:0] port,
                                     logic [nrc_pkg::VC_BITS-1:0] vc,
                                     int count, nrc_pkg::in_beat_t r);
    nrc_pkg::out_beat_t b;
    for (int i = 0; i < count; i++) begin
      b.out_port = port;
      b.out_vc   = vc + nrc_pkg::VC_BITS'(i);
      b.req_port = r.req_port_in;
      b.req_vc   = r.req_vc_in;
      b.last     = (i == count - 1);
      cand_q.push_back(b);
    end
  endfunction

  // Work out the candidate beats of one header under the current settings.
  function automatic void predict_route(nrc_pkg::in_beat_t r);
    int xo, yo, zo, ring;
    bit is3d, xnear, ynear;
    logic [nrc_pkg::PORT_BITS-1:0] port;
    logic [nrc_pkg::VC_BITS-1:0] vc;
    int count;
    xo = int'(r.dest_x) - int'(router_cfg.node_x);
    yo = int'(r.dest_y) - int'(router_cfg.node_y);
    zo = int'(r.dest_z) - int'(router_cfg.node_z);
    ring = int'(router_cfg.ring_size);
    is3d = (router_cfg.algorithm == nrc_pkg::ALG_XYZ);
    xnear = ((xo < 0 ? -xo : xo) * 2) <= ring;
    ynear = ((yo < 0 ? -yo : yo) * 2) <= ring;
    count = 1;
    port = nrc_pkg::PORT_EJECT;
    vc = nrc_pkg::VC0;
    if (xo == 0 && yo == 0 && (!is3d || zo == 0)) begin
      port = nrc_pkg::PORT_EJECT;
    end else if (router_cfg.algorithm == nrc_pkg::ALG_TORUS_XY) begin
      // Short way round the ring unless the offset passes the half ring.
      if (xo < 0) begin
        port = xnear ? nrc_pkg::PORT_MX : nrc_pkg::PORT_PX;
      end else if (xo > 0) begin
        port = xnear ? nrc_pkg::PORT_PX : nrc_pkg::PORT_MX;
        vc = nrc_pkg::VC1;
      end else if (yo < 0) begin
        port = ynear ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PY;
      end else begin
        port = ynear ? nrc_pkg::PORT_PY : nrc_pkg::PORT_MY;
        vc = nrc_pkg::VC1;
      end
    end else if (router_cfg.algorithm == nrc_pkg::ALG_ADAPT_VN) begin
      // Each direction has its own VC; a tie goes to the x port.
      if (xo == 0) begin
        port = yo < 0 ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PY;
      end else if (yo == 0) begin
        port = xo < 0 ? nrc_pkg::PORT_MX : nrc_pkg::PORT_PX;
      end else if (yo < 0 && xo < 0) begin
        port = r.level_my_vc2 > r.level_mx_vc0 ? nrc_pkg::PORT_MY : nrc_pkg::PORT_MX;
      end else if (yo < 0) begin
        port = r.level_my_vc2 > r.level_px_vc1 ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PX;
      end else if (xo < 0) begin
        port = r.level_py_vc3 > r.level_mx_vc0 ? nrc_pkg::PORT_PY : nrc_pkg::PORT_MX;
      end else begin
        port = r.level_py_vc3 > r.level_px_vc1 ? nrc_pkg::PORT_PY : nrc_pkg::PORT_PX;
      end
      case (port)
        nrc_pkg::PORT_PX: vc = nrc_pkg::VC1;
        nrc_pkg::PORT_MY: vc = nrc_pkg::VC2;
        nrc_pkg::PORT_PY: vc = nrc_pkg::VC3;
        default: vc = nrc_pkg::VC0;
      endcase
    end else if (router_cfg.algorithm == nrc_pkg::ALG_TURN) begin
      // Turn model: all on VC 0, and the +x, -y quadrant always leaves on +x.
      if (xo == 0) begin
        port = yo < 0 ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PY;
      end else if (yo == 0) begin
        port = xo < 0 ? nrc_pkg::PORT_MX : nrc_pkg::PORT_PX;
      end else if (yo < 0 && xo < 0) begin
        port = r.level_my_vc0 > r.level_mx_vc0 ? nrc_pkg::PORT_MY : nrc_pkg::PORT_MX;
      end else if (yo < 0) begin
        port = nrc_pkg::PORT_PX;
      end else if (xo < 0) begin
        port = r.level_py_vc0 > r.level_mx_vc0 ? nrc_pkg::PORT_PY : nrc_pkg::PORT_MX;
      end else begin
        port = r.level_py_vc0 > r.level_px_vc0 ? nrc_pkg::PORT_PY : nrc_pkg::PORT_PX;
      end
    end else begin
      // Dimension order (also for unused codes): z, then y, then x.
      if (is3d && zo != 0) begin
        port = zo < 0 ? nrc_pkg::PORT_MZ : nrc_pkg::PORT_PZ;
      end else if (yo != 0) begin
        port = yo < 0 ? nrc_pkg::PORT_MY : nrc_pkg::PORT_PY;
      end else begin
        port = xo < 0 ? nrc_pkg::PORT_MX : nrc_pkg::PORT_PX;
      end
      count = nrc_pkg::NUM_VCS;
    end
    push_cands(port, vc, count, r);
  endfunction

  function automatic dir_row_t mk_row(nrc_pkg::cfg_t c, logic [3:0] dx, logic [3:0] dy,
                                      logic [3:0] dz, logic [7:0] ylvl, logic [7:0] xlvl,
                                      logic fixed, logic [nrc_pkg::PORT_BITS-1:0] port,
                                      logic [nrc_pkg::VC_BITS-1:0] vc, logic [2:0] count);
    dir_row_t row;
    row.cfg = c;
    row.req = '0;
    row.req.dest_x = dx;
    row.req.dest_y = dy;
    row.req.dest_z = dz;
    row.req.level_my_vc0 = ylvl;
    row.req.level_my_vc2 = ylvl;
    row.req.level_py_vc0 = ylvl;
    row.req.level_py_vc3 = ylvl;
    row.req.level_mx_vc0 = xlvl;
    row.req.level_px_vc0 = xlvl;
    row.req.level_px_vc1 = xlvl;
    row.fixed = fixed;
    row.port = port;
    row.vc = vc;
    row.count = count;
    return row;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare every accepted candidate beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (cand_q.size() == 0) begin
        $error("candidate beat with nothing expected: port %0d vc %0d",
               out_data.out_port, out_data.out_vc);
        errors++;
      end else begin
        check_field("out_port", cand_q[0].out_port, out_data.out_port);
        check_field("out_vc", cand_q[0].out_vc, out_data.out_vc);
        check_field("req_port", cand_q[0].req_port, out_data.req_port);
        check_field("req_vc", cand_q[0].req_vc, out_data.req_vc);
        check_field("last", cand_q[0].last, out_data.last);
        void'(cand_q.pop_front());
        n_beats++;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall <= !rst && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Load all five registers in consecutive cycles while the block is idle.
  task automatic apply_cfg(nrc_pkg::cfg_t c);
    cfg_wr_en <= 1'b1;
    for (int idx = 0; idx < 5; idx++) begin
      cfg_index <= nrc_pkg::CFG_INDEX_BITS'(idx);
      case (nrc_pkg::CFG_INDEX_BITS'(idx))
        nrc_pkg::REG_NODE_X:    cfg_wdata <= {1'($urandom_range(1)), c.node_x};
        nrc_pkg::REG_NODE_Y:    cfg_wdata <= {1'($urandom_range(1)), c.node_y};
        nrc_pkg::REG_NODE_Z:    cfg_wdata <= {1'($urandom_range(1)), c.node_z};
        nrc_pkg::REG_ALGORITHM: cfg_wdata <= {2'($urandom_range(3)), c.algorithm};
        default:                cfg_wdata <= c.ring_size;
      endcase
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    router_cfg = c;
    n_settings++;
  endtask

  // Stop offering and wait until every expected candidate has come back.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (cand_q.size() != 0 && waited < WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cand_q.size() != 0) begin
      $error("%0d candidate beats never arrived", cand_q.size());
      errors++;
      cand_q.delete();
    end
  endtask

  // Offer one header; valid stays high after the beat unless the next gap lowers it.
  task automatic send_request(nrc_pkg::in_beat_t r, logic fixed,
                              logic [nrc_pkg::PORT_BITS-1:0] port,
                              logic [nrc_pkg::VC_BITS-1:0] vc, int count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    if (fixed) begin
      push_cands(port, vc, count, r);
    end else begin
      predict_route(r);
    end
    n_requests++;
  endtask

  function automatic logic [3:0] pick_coord();
    case ($urandom_range(3))
      0: return 4'd0;
      1: return 4'd15;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  function automatic nrc_pkg::cfg_t random_setting(int seg_no);
    nrc_pkg::cfg_t c;
    c.node_x = pick_coord();
    c.node_y = pick_coord();
    c.node_z = pick_coord();
    c.algorithm = nrc_pkg::ALG_BITS'(seg_no % 8);
    case ($urandom_range(4))
      0: c.ring_size = 5'd2;
      1: c.ring_size = nrc_pkg::RING_SIZE_RESET;
      2: c.ring_size = 5'($urandom_range(1));
      3: c.ring_size = 5'd31;
      default: c.ring_size = 5'($urandom_range(2, 16));
    endcase
    return c;
  endfunction

  // Mostly random headers, with local, same-row and same-column ones mixed in.
  function automatic nrc_pkg::in_beat_t random_request();
    nrc_pkg::in_beat_t r;
    int mode;
    logic [nrc_pkg::LEVEL_BITS-1:0] lvl;
    r = '0;
    r.dest_x = 4'($urandom_range(15));
    r.dest_y = 4'($urandom_range(15));
    r.dest_z = ($urandom_range(9) < 3) ? router_cfg.node_z : 4'($urandom_range(15));
    mode = $urandom_range(9);
    if (mode == 0) begin
      r.dest_x = router_cfg.node_x;
      r.dest_y = router_cfg.node_y;
    end else if (mode == 1) begin
      r.dest_x = router_cfg.node_x;
    end else if (mode == 2) begin
      r.dest_y = router_cfg.node_y;
    end
    r.req_port_in = nrc_pkg::PORT_BITS'($urandom_range(6));
    r.req_vc_in = nrc_pkg::VC_BITS'($urandom_range(3));
    r.level_mx_vc0 = nrc_pkg::LEVEL_BITS'($urandom_range(255));
    r.level_px_vc0 = nrc_pkg::LEVEL_BITS'($urandom_range(255));
    r.level_px_vc1 = nrc_pkg::LEVEL_BITS'($urandom_range(255));
    r.level_my_vc0 = nrc_pkg::LEVEL_BITS'($urandom_range(255));
    r.level_my_vc2 = nrc_pkg::LEVEL_BITS'($urandom_range(255));
    r.level_py_vc0 = nrc_pkg::LEVEL_BITS'($urandom_range(255));
    r.level_py_vc3 = nrc_pkg::LEVEL_BITS'($urandom_range(255));
    // Sometimes make every comparison a tie.
    if ($urandom_range(4) == 0) begin
      lvl = r.level_mx_vc0;
      r.level_px_vc0 = lvl;
      r.level_px_vc1 = lvl;
      r.level_my_vc0 = lvl;
      r.level_my_vc2 = lvl;
      r.level_py_vc0 = lvl;
      r.level_py_vc3 = lvl;
    end
    return r;
  endfunction

  // Main sequence: directed table, then three throttling phases of random work.
  initial begin
    nrc_pkg::cfg_t c;
    nrc_pkg::in_beat_t r;
    int seg_no;
    int items;

    dir_rows[0]  = mk_row(nrc_pkg::cfg_t'{4'd0, 4'd0, 4'd0, nrc_pkg::ALG_XY, 5'd16},
                          0, 0, 9, 0, 0, 1, nrc_pkg::PORT_EJECT, nrc_pkg::VC0, 1);
    dir_rows[1]  = mk_row(nrc_pkg::cfg_t'{4'd0, 4'd0, 4'd0, nrc_pkg::ALG_XY, 5'd16},
                          15, 15, 0, 255, 255, 1, nrc_pkg::PORT_PY, nrc_pkg::VC0, 4);
    dir_rows[2]  = mk_row(nrc_pkg::cfg_t'{4'd0, 4'd0, 4'd0, nrc_pkg::ALG_XY, 5'd16},
                          15, 0, 0, 0, 255, 1, nrc_pkg::PORT_PX, nrc_pkg::VC0, 4);
    dir_rows[3]  = mk_row(nrc_pkg::cfg_t'{4'd15, 4'd15, 4'd15, nrc_pkg::ALG_XY, 5'd16},
                          0, 15, 0, 255, 0, 1, nrc_pkg::PORT_MX, nrc_pkg::VC0, 4);
    dir_rows[4]  = mk_row(nrc_pkg::cfg_t'{4'd15, 4'd15, 4'd15, nrc_pkg::ALG_XY, 5'd16},
                          0, 0, 0, 0, 0, 1, nrc_pkg::PORT_MY, nrc_pkg::VC0, 4);
    dir_rows[5]  = mk_row(nrc_pkg::cfg_t'{4'd15, 4'd15, 4'd15, nrc_pkg::ALG_XY, 5'd16},
                          15, 15, 0, 0, 0, 1, nrc_pkg::PORT_EJECT, nrc_pkg::VC0, 1);
    dir_rows[6]  = mk_row(nrc_pkg::cfg_t'{4'd15, 4'd15, 4'd15, nrc_pkg::ALG_XYZ, 5'd16},
                          15, 15, 0, 0, 0, 1, nrc_pkg::PORT_MZ, nrc_pkg::VC0, 4);
    dir_rows[7]  = mk_row(nrc_pkg::cfg_t'{4'd15, 4'd15, 4'd15, nrc_pkg::ALG_XYZ, 5'd16},
                          15, 15, 15, 0, 0, 1, nrc_pkg::PORT_EJECT, nrc_pkg::VC0, 1);
    dir_rows[8]  = mk_row(nrc_pkg::cfg_t'{4'd0, 4'd0, 4'd0, nrc_pkg::ALG_XYZ, 5'd16},
                          3, 5, 15, 0, 0, 1, nrc_pkg::PORT_PZ, nrc_pkg::VC0, 4);
    dir_rows[9]  = mk_row(nrc_pkg::cfg_t'{4'd0, 4'd0, 4'd0, nrc_pkg::ALG_XYZ, 5'd16},
                          3, 5, 0, 0, 0, 1, nrc_pkg::PORT_PY, nrc_pkg::VC0, 4);
    // In XYZ mode a z offset alone keeps the header from ejecting.
    dir_rows[10] = mk_row(nrc_pkg::cfg_t'{4'd0, 4'd0, 4'd0, nrc_pkg::ALG_XYZ, 5'd16},
                          0, 0, 1, 0, 0, 1, nrc_pkg::PORT_PZ, nrc_pkg::VC0, 4);
    // Torus: offsets right at the half ring still go the short way.
    dir_rows[11] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_TORUS_XY, 5'd16},
                          15, 7, 0, 0, 0, 1, nrc_pkg::PORT_PX, nrc_pkg::VC1, 1);
    dir_rows[12] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_TORUS_XY, 5'd16},
                          0, 7, 0, 0, 0, 1, nrc_pkg::PORT_MX, nrc_pkg::VC0, 1);
    dir_rows[13] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_TORUS_XY, 5'd16},
                          7, 15, 0, 0, 0, 1, nrc_pkg::PORT_PY, nrc_pkg::VC1, 1);
    dir_rows[14] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_TORUS_XY, 5'd2},
                          9, 7, 0, 0, 0, 1, nrc_pkg::PORT_MX, nrc_pkg::VC1, 1);
    dir_rows[15] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_TORUS_XY, 5'd2},
                          7, 0, 0, 0, 0, 1, nrc_pkg::PORT_PY, nrc_pkg::VC0, 1);
    // A zero ring size makes every ring look long.
    dir_rows[16] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_TORUS_XY, 5'd0},
                          8, 7, 0, 0, 0, 1, nrc_pkg::PORT_MX, nrc_pkg::VC1, 1);
    dir_rows[17] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_ADAPT_VN, 5'd16},
                          7, 3, 0, 0, 0, 1, nrc_pkg::PORT_MY, nrc_pkg::VC2, 1);
    dir_rows[18] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_ADAPT_VN, 5'd16},
                          3, 3, 0, 5, 5, 1, nrc_pkg::PORT_MX, nrc_pkg::VC0, 1);
    dir_rows[19] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_ADAPT_VN, 5'd16},
                          12, 12, 0, 200, 10, 0, nrc_pkg::PORT_EJECT, nrc_pkg::VC0, 0);
    dir_rows[20] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_ADAPT_VN, 5'd16},
                          12, 3, 0, 255, 254, 0, nrc_pkg::PORT_EJECT, nrc_pkg::VC0, 0);
    // Turn model +x, -y quadrant ignores the levels entirely.
    dir_rows[21] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_TURN, 5'd16},
                          12, 3, 0, 255, 0, 1, nrc_pkg::PORT_PX, nrc_pkg::VC0, 1);
    dir_rows[22] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_TURN, 5'd16},
                          3, 12, 0, 9, 9, 1, nrc_pkg::PORT_MX, nrc_pkg::VC0, 1);
    dir_rows[23] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, nrc_pkg::ALG_TURN, 5'd16},
                          12, 12, 0, 255, 0, 0, nrc_pkg::PORT_EJECT, nrc_pkg::VC0, 0);
    dir_rows[24] = mk_row(nrc_pkg::cfg_t'{4'd7, 4'd7, 4'd0, ALG_UNUSED_HI, 5'd16},
                          3, 12, 0, 0, 0, 1, nrc_pkg::PORT_PY, nrc_pkg::VC0, 4);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    router_cfg = nrc_pkg::cfg_t'{4'd0, 4'd0, 4'd0, nrc_pkg::ALG_XY, nrc_pkg::RING_SIZE_RESET};
    @(posedge clk);

    // Directed table; the first rows run on the reset settings.
    send_idle_pct = 25;
    recv_idle_pct = 25;
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].cfg != router_cfg) begin
        wait_idle();
        apply_cfg(dir_rows[i].cfg);
      end
      r = dir_rows[i].req;
      r.req_port_in = nrc_pkg::PORT_BITS'(i % 7);
      r.req_vc_in = nrc_pkg::VC_BITS'(i % 4);
      send_request(r, dir_rows[i].fixed, dir_rows[i].port, dir_rows[i].vc,
                   int'(dir_rows[i].count));
    end

    // Random part: slow receiver, then slow sender, then full speed.
    seg_no = 0;
    for (int ph = 0; ph < 3; ph++) begin
      for (int seg = 0; seg < 5; seg++) begin
        wait_idle();
        send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 85 : 0;
        recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 37 : 0;
        c = random_setting(seg_no);
        if (seg_no == 5) begin
          c.algorithm = ALG_UNUSED_LO;
        end
        apply_cfg(c);
        seg_no++;
        items = SEG_ITEMS;
        // Long receiver hold-off while headers keep coming, to back up the pipe.
        if (ph == 2 && seg == 0) begin
          hold_req = HOLD_CYCLES;
          items = HOLD_ITEMS;
        end
        for (int k = 0; k < items; k++) begin
          send_request(random_request(), 1'b0, nrc_pkg::PORT_EJECT, nrc_pkg::VC0, 0);
        end
      end
    end

    wait_idle();
    $display("Covered %0d header requests (%0d from the table) under %0d router settings,",
             n_requests, NUM_DIR, n_settings);
    $display("all algorithm codes and both throttling mixes; %0d candidate beats checked.",
             n_beats);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
